@@ hdl/assert_macros.svh @@
// assertion helpers, clocked on clk_i and disabled while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every edge
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// consequence that must hold in the cycle after the trigger
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/xbse_pkg.sv @@
package xbse_pkg;

  // opcodes
  localparam logic [7:0] OP_XOR_RM = 8'h32;
  localparam logic [7:0] OP_JNO    = 8'h71;
  localparam logic [7:0] OP_JC     = 8'h72;
  localparam logic [7:0] OP_JNC    = 8'h73;
  localparam logic [7:0] OP_JZ     = 8'h74;
  localparam logic [7:0] OP_JNZ    = 8'h75;
  localparam logic [7:0] OP_JS     = 8'h78;
  localparam logic [7:0] OP_JNS    = 8'h79;
  localparam logic [7:0] OP_JP     = 8'h7A;
  localparam logic [7:0] OP_JNP    = 8'h7B;
  localparam logic [7:0] OP_SAHF   = 8'h9E;
  localparam logic [7:0] OP_LAHF   = 8'h9F;
  localparam logic [7:0] OP_MOV_AL = 8'hB0;
  localparam logic [7:0] OP_MOV_CL = 8'hB1;
  localparam logic [7:0] OP_MOV_AH = 8'hB4;
  localparam logic [7:0] OP_SHL1   = 8'hD0;
  localparam logic [7:0] OP_SHR_CL = 8'hD2;
  localparam logic [7:0] OP_JMPF   = 8'hEA;
  localparam logic [7:0] OP_CLI    = 8'hFA;

  // accepted modrm bytes for the shift group
  localparam logic [7:0] MODRM_SHL_AL = 8'hE0;
  localparam logic [7:0] MODRM_SHR_AH = 8'hEC;

  // 8-bit register codes
  localparam logic [2:0] R8_AL = 3'd0;
  localparam logic [2:0] R8_CL = 3'd1;
  localparam logic [2:0] R8_AH = 3'd4;

  // flag bit positions
  localparam int unsigned FL_CF = 0;
  localparam int unsigned FL_PF = 2;
  localparam int unsigned FL_ZF = 6;
  localparam int unsigned FL_SF = 7;
  localparam int unsigned FL_OF = 11;

  localparam logic [15:0] SAHF_KEEP = 16'hFF2A;
  localparam logic [7:0]  SAHF_LOAD = 8'hD5;
  localparam logic [15:0] CLI_MASK  = 16'hFDFF;

  // reset values
  localparam logic [15:0] CS_RESET = 16'hF000;
  localparam logic [15:0] IP_RESET = 16'hFFF0;
  localparam logic [15:0] FL_RESET = 16'hF002;

  localparam int unsigned IN_W  = 40;
  localparam int unsigned OUT_W = 112;

endpackage

@@ hdl/x86_byte_subset_execute.sv @@
// Executes one instruction of a small 8086 subset per request. The input request carries the
// opcode and the four bytes that follow it at CS:IP; the result carries IP, CS, AX, BX, CX,
// DX and FLAGS after execution plus an unsupported flag. A new request is taken every cycle
// and results leave at one per cycle while the result side is not back-pressured; a request
// is held in the input register, which feeds an execute stage that reads and writes the
// architectural registers and loads the result register. Reset puts CS=F000h, IP=FFF0h,
// FLAGS=F002h and clears the general registers.
`include "assert_macros.svh"

module x86_byte_subset_execute
  import xbse_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // opcode, byte1, byte2, byte3, byte4
  input  logic [39:0]  s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // out_ip, out_cs, out_ax, out_bx, out_cx, out_dx, out_flags
  output logic [111:0] m_axis_tdata_o,
  // unsupported
  output logic         m_axis_tuser_o
);

  logic              in_vld_q, in_vld_d;
  logic [IN_W-1:0]   in_data_q;
  logic              out_vld_q, out_vld_d;
  logic [OUT_W-1:0]  out_data_q;
  logic              out_unsup_q;
  logic              s_accept, exec_go;

  logic [15:0] ax_q, bx_q, cx_q, dx_q, cs_q, ip_q, fl_q;
  logic [15:0] ax_d, bx_d, cx_d, dx_d, cs_d, ip_d, fl_d;
  logic        unsup_d;

  logic [7:0]  op, b1, b2, b3, b4;
  logic        wr_en;
  logic [2:0]  wr_code;
  logic [7:0]  wr_val;
  logic        is_jcc, take;
  logic [7:0]  res8, shr_old, shr_cnt, shr_cm1;
  logic [15:0] fl_tmp;

  function automatic logic [7:0] get8(input logic [2:0] code, input logic [15:0] a,
                                      input logic [15:0] c, input logic [15:0] d,
                                      input logic [15:0] b);
    logic [15:0] r;
    case (code[1:0])
      2'd0:    r = a;
      2'd1:    r = c;
      2'd2:    r = d;
      default: r = b;
    endcase
    return code[2] ? r[15:8] : r[7:0];
  endfunction

  // sign, zero and parity from an 8-bit result
  function automatic logic [15:0] szp(input logic [15:0] f, input logic [7:0] v);
    logic [15:0] o;
    o        = f;
    o[FL_SF] = v[7];
    o[FL_ZF] = (v == 8'h00);
    o[FL_PF] = ~(^v);
    return o;
  endfunction

  assign exec_go         = in_vld_q && (!out_vld_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_vld_q || exec_go;
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;

  assign op = in_data_q[7:0];
  assign b1 = in_data_q[15:8];
  assign b2 = in_data_q[23:16];
  assign b3 = in_data_q[31:24];
  assign b4 = in_data_q[39:32];

  always_comb begin
    ip_d    = ip_q;
    cs_d    = cs_q;
    fl_d    = fl_q;
    unsup_d = 1'b0;
    wr_en   = 1'b0;
    wr_code = R8_AL;
    wr_val  = 8'h00;
    is_jcc  = 1'b0;
    take    = 1'b0;
    res8    = 8'h00;
    fl_tmp  = fl_q;
    shr_old = ax_q[15:8];
    shr_cnt = cx_q[7:0];
    shr_cm1 = cx_q[7:0] - 8'd1;
    case (op)
      OP_XOR_RM: begin
        if (b1[7:6] == 2'b11) begin
          res8           = get8(b1[5:3], ax_q, cx_q, dx_q, bx_q) ^
                           get8(b1[2:0], ax_q, cx_q, dx_q, bx_q);
          wr_en          = 1'b1;
          wr_code        = b1[5:3];
          wr_val         = res8;
          fl_tmp[FL_CF]  = 1'b0;
          fl_tmp[FL_OF]  = 1'b0;
          fl_d           = szp(fl_tmp, res8);
        end else begin
          unsup_d = 1'b1;
        end
        ip_d = ip_q + 16'd2;
      end
      OP_JNO: begin is_jcc = 1'b1; take = !fl_q[FL_OF]; end
      OP_JC:  begin is_jcc = 1'b1; take =  fl_q[FL_CF]; end
      OP_JNC: begin is_jcc = 1'b1; take = !fl_q[FL_CF]; end
      OP_JZ:  begin is_jcc = 1'b1; take =  fl_q[FL_ZF]; end
      OP_JNZ: begin is_jcc = 1'b1; take = !fl_q[FL_ZF]; end
      OP_JS:  begin is_jcc = 1'b1; take =  fl_q[FL_SF]; end
      OP_JNS: begin is_jcc = 1'b1; take = !fl_q[FL_SF]; end
      OP_JP:  begin is_jcc = 1'b1; take =  fl_q[FL_PF]; end
      OP_JNP: begin is_jcc = 1'b1; take = !fl_q[FL_PF]; end
      OP_SAHF: begin
        fl_d = (fl_q & SAHF_KEEP) | {8'h00, ax_q[15:8] & SAHF_LOAD};
        ip_d = ip_q + 16'd1;
      end
      OP_LAHF: begin
        wr_en   = 1'b1;
        wr_code = R8_AH;
        wr_val  = fl_q[7:0];
        ip_d    = ip_q + 16'd1;
      end
      OP_MOV_AL: begin
        wr_en = 1'b1; wr_code = R8_AL; wr_val = b1; ip_d = ip_q + 16'd2;
      end
      OP_MOV_CL: begin
        wr_en = 1'b1; wr_code = R8_CL; wr_val = b1; ip_d = ip_q + 16'd2;
      end
      OP_MOV_AH: begin
        wr_en = 1'b1; wr_code = R8_AH; wr_val = b1; ip_d = ip_q + 16'd2;
      end
      OP_SHL1: begin
        if (b1 == MODRM_SHL_AL) begin
          res8          = {ax_q[6:0], 1'b0};
          wr_en         = 1'b1;
          wr_code       = R8_AL;
          wr_val        = res8;
          fl_tmp[FL_CF] = ax_q[7];
          fl_tmp[FL_OF] = ax_q[7] ^ ax_q[6];
          fl_d          = szp(fl_tmp, res8);
        end else begin
          unsup_d = 1'b1;
        end
        ip_d = ip_q + 16'd2;
      end
      OP_SHR_CL: begin
        if (b1 == MODRM_SHR_AH) begin
          // zero count leaves AH and flags alone
          if (shr_cnt != 8'd0) begin
            res8          = (shr_cnt >= 8'd8) ? 8'h00 : (shr_old >> shr_cnt[2:0]);
            wr_en         = 1'b1;
            wr_code       = R8_AH;
            wr_val        = res8;
            fl_tmp[FL_CF] = (shr_cnt <= 8'd8) ? shr_old[shr_cm1[2:0]] : 1'b0;
            fl_tmp[FL_OF] = (shr_cnt == 8'd1) && shr_old[7];
            fl_d          = szp(fl_tmp, res8);
          end
        end else begin
          unsup_d = 1'b1;
        end
        ip_d = ip_q + 16'd2;
      end
      OP_JMPF: begin
        ip_d = {b2, b1};
        cs_d = {b4, b3};
      end
      OP_CLI: begin
        fl_d = fl_q & CLI_MASK;
        ip_d = ip_q + 16'd1;
      end
      default: begin
        unsup_d = 1'b1;
        ip_d    = ip_q + 16'd1;
      end
    endcase
    if (is_jcc) begin
      ip_d = ip_q + 16'd2 + (take ? {{8{b1[7]}}, b1} : 16'h0000);
    end
  end

  // byte write-back into the general registers
  always_comb begin
    ax_d = ax_q;
    cx_d = cx_q;
    dx_d = dx_q;
    bx_d = bx_q;
    if (wr_en) begin
      case (wr_code[1:0])
        2'd0:    ax_d = wr_code[2] ? {wr_val, ax_q[7:0]} : {ax_q[15:8], wr_val};
        2'd1:    cx_d = wr_code[2] ? {wr_val, cx_q[7:0]} : {cx_q[15:8], wr_val};
        2'd2:    dx_d = wr_code[2] ? {wr_val, dx_q[7:0]} : {dx_q[15:8], wr_val};
        default: bx_d = wr_code[2] ? {wr_val, bx_q[7:0]} : {bx_q[15:8], wr_val};
      endcase
    end
  end

  always_comb begin
    in_vld_d = in_vld_q;
    if (s_accept) begin
      in_vld_d = 1'b1;
    end else if (exec_go) begin
      in_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (exec_go) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      ax_q      <= 16'h0000;
      bx_q      <= 16'h0000;
      cx_q      <= 16'h0000;
      dx_q      <= 16'h0000;
      cs_q      <= CS_RESET;
      ip_q      <= IP_RESET;
      fl_q      <= FL_RESET;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      if (exec_go) begin
        ax_q <= ax_d;
        bx_q <= bx_d;
        cx_q <= cx_d;
        dx_q <= dx_d;
        cs_q <= cs_d;
        ip_q <= ip_d;
        fl_q <= fl_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_data_q <= s_axis_tdata_i;
    end
    if (exec_go) begin
      out_data_q  <= {fl_d, dx_d, cx_d, bx_d, ax_d, cs_d, ip_d};
      out_unsup_q <= unsup_d;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_unsup_q;

  `ASSERT_NEXT(a_exec_fills_out, exec_go, out_vld_q, "executed request gave no result")
  `ASSERT_NEXT(a_unsup_keeps_gpr, exec_go && unsup_d,
               $stable(ax_q) && $stable(bx_q) && $stable(cx_q) && $stable(dx_q),
               "unsupported instruction changed a general register")
  `ASSERT_NEXT(a_cs_only_far_jmp, !(exec_go && (op == OP_JMPF)), $stable(cs_q),
               "cs changed outside a far jump")
  `ASSERT_ALWAYS(a_no_accept_full,
                 !in_vld_q || s_axis_tready_o || (out_vld_q && !m_axis_tready_i),
                 "input stage stalled without a blocked result")

endmodule

@@ test/tb_x86_byte_subset_execute.sv @@
module tb_x86_byte_subset_execute;
  import xbse_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_REQUESTS = 800;
  localparam int unsigned STUCK_LIMIT     = 1000;
  localparam int unsigned HOLD_CYCLES     = 120;
  localparam int unsigned DRAIN_CYCLES    = 8;

  // opcodes outside the subset, used to exercise the unsupported path
  localparam logic [7:0] OP_ADD_RM = 8'h00;
  localparam logic [7:0] OP_GRP5   = 8'hFF;

  localparam logic [7:0] KNOWN_OPS [19] = '{
    OP_XOR_RM, OP_JNO, OP_JC, OP_JNC, OP_JZ, OP_JNZ, OP_JS, OP_JNS, OP_JP, OP_JNP,
    OP_SAHF, OP_LAHF, OP_MOV_AL, OP_MOV_CL, OP_MOV_AH, OP_SHL1, OP_SHR_CL, OP_JMPF,
    OP_CLI
  };

  typedef struct packed {
    logic [15:0] ip;
    logic [15:0] cs;
    logic [15:0] ax;
    logic [15:0] bx;
    logic [15:0] cx;
    logic [15:0] dx;
    logic [15:0] flags;
    logic        unsup;
  } arch_snapshot_t;

  class exec_checker;
    logic [15:0] ax, bx, cx, dx, cs, ip, fl;
    arch_snapshot_t expected_states[$];
    int unsigned errors;
    int unsigned results_seen;

    function new();
      ax = '0;
      bx = '0;
      cx = '0;
      dx = '0;
      cs = CS_RESET;
      ip = IP_RESET;
      fl = FL_RESET;
      errors = 0;
      results_seen = 0;
    endfunction

    function logic [7:0] rd8(logic [2:0] code);
      logic [15:0] w;
      case (code[1:0])
        2'd0: w = ax;
        2'd1: w = cx;
        2'd2: w = dx;
        default: w = bx;
      endcase
      return code[2] ? w[15:8] : w[7:0];
    endfunction

    function void wr8(logic [2:0] code, logic [7:0] v);
      case ({code[1:0], code[2]})
        3'b000: ax[7:0] = v;
        3'b001: ax[15:8] = v;
        3'b010: cx[7:0] = v;
        3'b011: cx[15:8] = v;
        3'b100: dx[7:0] = v;
        3'b101: dx[15:8] = v;
        3'b110: bx[7:0] = v;
        default: bx[15:8] = v;
      endcase
    endfunction

    function void szp(logic [7:0] v);
      fl[FL_SF] = v[7];
      fl[FL_ZF] = (v == 8'h00);
      fl[FL_PF] = ~^v;
    endfunction

    function void take_request(logic [39:0] d);
      logic [7:0] op, b1, r, old;
      logic is_jump, taken, unsup;
      int unsigned n;
      arch_snapshot_t s;
      op = d[7:0];
      b1 = d[15:8];
      is_jump = 1'b0;
      taken = 1'b0;
      unsup = 1'b0;
      case (op)
        OP_XOR_RM: begin
          if (b1[7:6] == 2'b11) begin
            r = rd8(b1[5:3]) ^ rd8(b1[2:0]);
            wr8(b1[5:3], r);
            fl[FL_CF] = 1'b0;
            fl[FL_OF] = 1'b0;
            szp(r);
          end else begin
            unsup = 1'b1;
          end
          ip += 16'd2;
        end
        OP_JNO: begin is_jump = 1'b1; taken = !fl[FL_OF]; end
        OP_JC:  begin is_jump = 1'b1; taken = fl[FL_CF]; end
        OP_JNC: begin is_jump = 1'b1; taken = !fl[FL_CF]; end
        OP_JZ:  begin is_jump = 1'b1; taken = fl[FL_ZF]; end
        OP_JNZ: begin is_jump = 1'b1; taken = !fl[FL_ZF]; end
        OP_JS:  begin is_jump = 1'b1; taken = fl[FL_SF]; end
        OP_JNS: begin is_jump = 1'b1; taken = !fl[FL_SF]; end
        OP_JP:  begin is_jump = 1'b1; taken = fl[FL_PF]; end
        OP_JNP: begin is_jump = 1'b1; taken = !fl[FL_PF]; end
        OP_SAHF: begin
          fl = (fl & SAHF_KEEP) | {8'h00, rd8(R8_AH) & SAHF_LOAD};
          ip += 16'd1;
        end
        OP_LAHF: begin
          wr8(R8_AH, fl[7:0]);
          ip += 16'd1;
        end
        OP_MOV_AL: begin wr8(R8_AL, b1); ip += 16'd2; end
        OP_MOV_CL: begin wr8(R8_CL, b1); ip += 16'd2; end
        OP_MOV_AH: begin wr8(R8_AH, b1); ip += 16'd2; end
        OP_SHL1: begin
          if (b1 == MODRM_SHL_AL) begin
            old = rd8(R8_AL);
            r = {old[6:0], 1'b0};
            wr8(R8_AL, r);
            fl[FL_CF] = old[7];
            fl[FL_OF] = old[7] ^ r[7];
            szp(r);
          end else begin
            unsup = 1'b1;
          end
          ip += 16'd2;
        end
        OP_SHR_CL: begin
          if (b1 == MODRM_SHR_AH) begin
            n = 32'(rd8(R8_CL));
            old = rd8(R8_AH);
            // a zero count leaves AH and the flags alone
            if (n != 0) begin
              r = (n >= 8) ? 8'h00 : old >> n;
              wr8(R8_AH, r);
              fl[FL_CF] = (n <= 8) ? old[n - 1] : 1'b0;
              fl[FL_OF] = (n == 1) ? old[7] : 1'b0;
              szp(r);
            end
          end else begin
            unsup = 1'b1;
          end
          ip += 16'd2;
        end
        OP_JMPF: begin
          ip = d[23:8];
          cs = d[39:24];
        end
        OP_CLI: begin
          fl &= CLI_MASK;
          ip += 16'd1;
        end
        default: begin
          unsup = 1'b1;
          ip += 16'd1;
        end
      endcase
      if (is_jump) begin
        ip += 16'd2;
        if (taken) ip += {{8{b1[7]}}, b1};
      end
      s.ip = ip;
      s.cs = cs;
      s.ax = ax;
      s.bx = bx;
      s.cx = cx;
      s.dx = dx;
      s.flags = fl;
      s.unsup = unsup;
      expected_states.push_back(s);
    endfunction

    function void compare_field(string name, logic [15:0] exp_v, logic [15:0] got_v);
      if (exp_v !== got_v) begin
        $error("%s mismatch: expected %h, got %h", name, exp_v, got_v);
        errors++;
      end
    endfunction

    function void check_result(logic [111:0] d, logic unsup);
      arch_snapshot_t e;
      results_seen++;
      if (expected_states.size() == 0) begin
        $error("result with no request outstanding: tdata %h", d);
        errors++;
        return;
      end
      e = expected_states.pop_front();
      compare_field("out_ip", e.ip, d[15:0]);
      compare_field("out_cs", e.cs, d[31:16]);
      compare_field("out_ax", e.ax, d[47:32]);
      compare_field("out_bx", e.bx, d[63:48]);
      compare_field("out_cx", e.cx, d[79:64]);
      compare_field("out_dx", e.dx, d[95:80]);
      compare_field("out_flags", e.flags, d[111:96]);
      compare_field("unsupported", {15'd0, e.unsup}, {15'd0, unsup});
    endfunction
  endclass

  logic         clk_i = 1'b0;
  logic         rst_ni;
  logic         s_tvalid;
  logic         s_axis_tready_o;
  // opcode, byte1, byte2, byte3, byte4
  logic [39:0]  s_tdata;
  logic         m_axis_tvalid_o;
  logic         m_tready;
  // out_ip, out_cs, out_ax, out_bx, out_cx, out_dx, out_flags
  logic [111:0] m_axis_tdata_o;
  // unsupported
  logic         m_axis_tuser_o;

  bit           calm;
  int unsigned  stuck_cycles = 0;
  exec_checker  chk = new();

  x86_byte_subset_execute u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // request and result monitor plus stall watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_tready) chk.check_result(m_axis_tdata_o, m_axis_tuser_o);
      if (s_tvalid && s_axis_tready_o) chk.take_request(s_tdata);
      if ((m_axis_tvalid_o && m_tready) || (s_tvalid && s_axis_tready_o)) stuck_cycles = 0;
      else stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // result side: random backpressure, one long hold-off to fill the pipe
  initial begin
    int unsigned hold_left;
    bit held;
    hold_left = 0;
    held = 1'b0;
    m_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!held && chk.results_seen >= 250) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= calm || ($urandom_range(0, 99) >= 9);
      end
    end
  end

  task automatic offer(input logic [7:0] op, input logic [7:0] b1,
                       input logic [7:0] b2 = 8'h00, input logic [7:0] b3 = 8'h00,
                       input logic [7:0] b4 = 8'h00);
    if (!calm && $urandom_range(0, 99) < 9) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {b4, b3, b2, b1, op};
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  initial begin
    logic [7:0] op, b1;
    logic [31:0] r;
    rst_ni   = 1'b0;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    calm     = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: field extremes, each instruction but the conditional jumps other than JZ and JNZ, shift corner counts
    offer(OP_MOV_AL, 8'hFF);
    offer(OP_MOV_CL, 8'h00);
    offer(OP_MOV_AH, 8'h81);
    offer(OP_XOR_RM, {2'b11, R8_AL, R8_AH});
    offer(OP_XOR_RM, {2'b11, R8_AH, R8_AH});
    offer(OP_XOR_RM, 8'h06);
    offer(OP_SHL1, MODRM_SHL_AL);
    offer(OP_SHL1, 8'hE8);
    offer(OP_MOV_AH, 8'hC3);
    offer(OP_SHR_CL, MODRM_SHR_AH);
    offer(OP_MOV_CL, 8'h01);
    offer(OP_SHR_CL, MODRM_SHR_AH);
    offer(OP_MOV_AH, 8'hFF);
    offer(OP_MOV_CL, 8'h08);
    offer(OP_SHR_CL, MODRM_SHR_AH);
    offer(OP_MOV_AH, 8'hA5);
    offer(OP_MOV_CL, 8'hFF);
    offer(OP_SHR_CL, MODRM_SHR_AH);
    offer(OP_SHR_CL, 8'hED);
    offer(OP_LAHF, 8'h00);
    offer(OP_SAHF, 8'hFF);
    offer(OP_CLI, 8'h00);
    offer(OP_JZ, 8'h80);
    offer(OP_JNZ, 8'h7F);
    offer(OP_JMPF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    offer(OP_JMPF, 8'h00, 8'h00, 8'h00, 8'h00);
    offer(OP_ADD_RM, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    offer(OP_GRP5, 8'h00);

    // random: mostly well-formed instructions, some arbitrary opcodes
    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      calm = (i >= 300 && i < 450);
      r  = $urandom;
      b1 = 8'($urandom);
      if ($urandom_range(0, 99) < 85) begin
        op = KNOWN_OPS[$urandom_range(0, 18)];
        case (op)
          OP_XOR_RM: if ($urandom_range(0, 9) < 8) b1[7:6] = 2'b11;
          OP_SHL1:   if ($urandom_range(0, 9) < 8) b1 = MODRM_SHL_AL;
          OP_SHR_CL: if ($urandom_range(0, 9) < 8) b1 = MODRM_SHR_AH;
          OP_MOV_CL: if ($urandom_range(0, 1) == 1) b1 = 8'($urandom_range(0, 10));
          default: ;
        endcase
      end else begin
        op = 8'($urandom);
      end
      offer(op, b1, r[7:0], r[15:8], r[23:16]);
    end
    calm = 1'b0;
    s_tvalid <= 1'b0;

    while (chk.expected_states.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (chk.errors == 0 && chk.expected_states.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
